// ===== src/tks_pkg.sv =====
package tks_pkg;

    // default width of the byte position counter
    localparam int POS_BITS_DEF = 16;

    // item records held between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QIDX_BITS   = $clog2(QUEUE_DEPTH);

    localparam int CH_BITS    = 8;
    localparam int KIND_BITS  = 5;
    localparam int START_BITS = 16;
    localparam int LEN_BITS   = 16;

    // token kinds
    localparam logic [KIND_BITS-1:0] KIND_ILLEGAL   = 5'd0;
    localparam logic [KIND_BITS-1:0] KIND_EOF       = 5'd1;
    localparam logic [KIND_BITS-1:0] KIND_IDENT     = 5'd2;
    localparam logic [KIND_BITS-1:0] KIND_INT       = 5'd3;
    localparam logic [KIND_BITS-1:0] KIND_ASSIGN    = 5'd4;
    localparam logic [KIND_BITS-1:0] KIND_EQ        = 5'd5;
    localparam logic [KIND_BITS-1:0] KIND_BANG      = 5'd6;
    localparam logic [KIND_BITS-1:0] KIND_NE        = 5'd7;
    localparam logic [KIND_BITS-1:0] KIND_COLON     = 5'd8;
    localparam logic [KIND_BITS-1:0] KIND_ALLOCATE  = 5'd9;
    localparam logic [KIND_BITS-1:0] KIND_SEMICOLON = 5'd10;
    localparam logic [KIND_BITS-1:0] KIND_COMMA     = 5'd11;
    localparam logic [KIND_BITS-1:0] KIND_LPAREN    = 5'd12;
    localparam logic [KIND_BITS-1:0] KIND_RPAREN    = 5'd13;
    localparam logic [KIND_BITS-1:0] KIND_PLUS      = 5'd14;
    localparam logic [KIND_BITS-1:0] KIND_MINUS     = 5'd15;
    localparam logic [KIND_BITS-1:0] KIND_MULT      = 5'd16;
    localparam logic [KIND_BITS-1:0] KIND_LT        = 5'd17;
    localparam logic [KIND_BITS-1:0] KIND_GT        = 5'd18;
    localparam logic [KIND_BITS-1:0] KIND_DIV       = 5'd19;
    localparam logic [KIND_BITS-1:0] KIND_LBRACE    = 5'd20;
    localparam logic [KIND_BITS-1:0] KIND_RBRACE    = 5'd21;

    // open run codes
    localparam logic [1:0] RUN_NONE  = 2'd0;
    localparam logic [1:0] RUN_IDENT = 2'd1;
    localparam logic [1:0] RUN_INT   = 2'd2;

    // pending operator codes
    localparam logic [1:0] PEND_NONE  = 2'd0;
    localparam logic [1:0] PEND_EQ    = 2'd1;
    localparam logic [1:0] PEND_BANG  = 2'd2;
    localparam logic [1:0] PEND_COLON = 2'd3;

    // characters
    localparam logic [CH_BITS-1:0] CH_NUL    = 8'h00;
    localparam logic [CH_BITS-1:0] CH_TAB    = 8'h09;
    localparam logic [CH_BITS-1:0] CH_LF     = 8'h0A;
    localparam logic [CH_BITS-1:0] CH_CR     = 8'h0D;
    localparam logic [CH_BITS-1:0] CH_SPACE  = 8'h20;
    localparam logic [CH_BITS-1:0] CH_BANG   = 8'h21;
    localparam logic [CH_BITS-1:0] CH_LPAREN = 8'h28;
    localparam logic [CH_BITS-1:0] CH_RPAREN = 8'h29;
    localparam logic [CH_BITS-1:0] CH_STAR   = 8'h2A;
    localparam logic [CH_BITS-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CH_BITS-1:0] CH_COMMA  = 8'h2C;
    localparam logic [CH_BITS-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CH_BITS-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CH_BITS-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_BITS-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_BITS-1:0] CH_COLON  = 8'h3A;
    localparam logic [CH_BITS-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CH_BITS-1:0] CH_LT     = 8'h3C;
    localparam logic [CH_BITS-1:0] CH_EQ     = 8'h3D;
    localparam logic [CH_BITS-1:0] CH_GT     = 8'h3E;
    localparam logic [CH_BITS-1:0] CH_UP_A   = 8'h41;
    localparam logic [CH_BITS-1:0] CH_UP_Z   = 8'h5A;
    localparam logic [CH_BITS-1:0] CH_UNDER  = 8'h5F;
    localparam logic [CH_BITS-1:0] CH_LO_A   = 8'h61;
    localparam logic [CH_BITS-1:0] CH_LO_Z   = 8'h7A;
    localparam logic [CH_BITS-1:0] CH_LBRACE = 8'h7B;
    localparam logic [CH_BITS-1:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [KIND_BITS-1:0]  kind;
        logic [START_BITS-1:0] start;
        logic [LEN_BITS-1:0]   len;
        logic                  last;
    } t_tok;

    // all tokens caused by one item, in order
    typedef struct packed {
        logic [1:0] cnt;
        t_tok       tok0;
        t_tok       tok1;
    } t_rec;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

    function automatic logic is_alpha(input logic [CH_BITS-1:0] c);
        return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)
            || c == CH_UNDER;
    endfunction

    function automatic logic is_decimal(input logic [CH_BITS-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic logic is_space(input logic [CH_BITS-1:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic [KIND_BITS-1:0] single_kind(input logic [CH_BITS-1:0] c);
        logic [KIND_BITS-1:0] k;
        unique case (c)
            CH_SEMI:   k = KIND_SEMICOLON;
            CH_COMMA:  k = KIND_COMMA;
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_PLUS:   k = KIND_PLUS;
            CH_MINUS:  k = KIND_MINUS;
            CH_STAR:   k = KIND_MULT;
            CH_LT:     k = KIND_LT;
            CH_GT:     k = KIND_GT;
            CH_SLASH:  k = KIND_DIV;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            default:   k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

    // operator emitted alone when no '=' follows
    function automatic logic [KIND_BITS-1:0] lone_kind(input logic [1:0] p);
        logic [KIND_BITS-1:0] k;
        unique case (p)
            PEND_EQ:    k = KIND_ASSIGN;
            PEND_BANG:  k = KIND_BANG;
            PEND_COLON: k = KIND_COLON;
            default:    k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

    // operator completed by '='
    function automatic logic [KIND_BITS-1:0] pair_kind(input logic [1:0] p);
        logic [KIND_BITS-1:0] k;
        unique case (p)
            PEND_EQ:    k = KIND_EQ;
            PEND_BANG:  k = KIND_NE;
            PEND_COLON: k = KIND_ALLOCATE;
            default:    k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

// ===== src/tks_if.sv =====
interface tks_in_if import tks_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CH_BITS-1:0] ch;
    logic               is_end;

    modport source (output valid, output ch, output is_end, input ready);
    modport sink (input valid, input ch, input is_end, output ready);
endinterface

interface tks_out_if import tks_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [KIND_BITS-1:0]  kind;
    logic [START_BITS-1:0] start_res;
    logic [LEN_BITS-1:0]   length;
    logic                  last;

    modport source (output valid, output kind, output start_res, output length,
                    output last, input ready);
    modport sink (input valid, input kind, input start_res, input length,
                  input last, output ready);
endinterface

// ===== src/tks_front.sv =====
module tks_front import tks_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tks_in_if.sink      i_in,
    input  t_qstat      i_qstat,
    output logic        o_push,
    output t_rec        o_rec
);

    logic [POS_BITS-1:0] r_pos, n_pos;
    logic [1:0]          r_run_kind, n_run_kind;
    logic [POS_BITS-1:0] r_run_start, n_run_start;
    logic [LEN_BITS-1:0] r_run_len, n_run_len;
    logic [1:0]          r_pend, n_pend;

    logic                accept;
    logic                fin;
    logic [CH_BITS-1:0]  c;
    logic [POS_BITS-1:0] pos_m1;
    logic                a_on, b_on;
    t_tok                a_tok, b_tok, pend_tok, run_tok, eof_tok;

    assign i_in.ready = !i_qstat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign c          = i_in.ch;
    assign fin        = i_in.is_end || c == CH_NUL;
    assign pos_m1     = r_pos - 1'b1;

    always_comb begin
        pend_tok = '{kind: lone_kind(r_pend), start: START_BITS'(pos_m1),
                     len: LEN_BITS'(1), last: 1'b0};
        run_tok  = '{kind: (r_run_kind == RUN_IDENT) ? KIND_IDENT : KIND_INT,
                     start: START_BITS'(r_run_start), len: r_run_len, last: 1'b0};
        eof_tok  = '{kind: KIND_EOF, start: START_BITS'(r_pos), len: '0, last: 1'b0};
    end

    always_comb begin
        a_on        = 1'b0;
        b_on        = 1'b0;
        a_tok       = pend_tok;
        b_tok       = eof_tok;
        n_pos       = r_pos + 1'b1;
        n_run_kind  = r_run_kind;
        n_run_start = r_run_start;
        n_run_len   = r_run_len;
        n_pend      = PEND_NONE;
        if (fin) begin
            // flush whatever is open, then eof; pending and run never coexist
            a_on        = r_pend != PEND_NONE || r_run_kind != RUN_NONE;
            a_tok       = (r_pend != PEND_NONE) ? pend_tok : run_tok;
            b_on        = 1'b1;
            b_tok       = eof_tok;
            n_pos       = '0;
            n_run_kind  = RUN_NONE;
            n_run_start = '0;
            n_run_len   = '0;
        end else if (r_pend != PEND_NONE && c == CH_EQ) begin
            a_on  = 1'b1;
            a_tok = '{kind: pair_kind(r_pend), start: START_BITS'(pos_m1),
                      len: LEN_BITS'(2), last: 1'b0};
        end else begin
            a_on = r_pend != PEND_NONE;
            if ((r_run_kind == RUN_IDENT && is_alpha(c))
                    || (r_run_kind == RUN_INT && is_decimal(c))) begin
                n_run_len = (r_run_len == '1) ? r_run_len : r_run_len + 1'b1;
            end else begin
                if (r_run_kind != RUN_NONE) begin
                    a_on  = 1'b1;
                    a_tok = run_tok;
                end
                n_run_kind = RUN_NONE;
                n_run_len  = '0;
                if (is_space(c)) begin
                    n_run_kind = RUN_NONE;
                end else if (is_alpha(c)) begin
                    n_run_kind  = RUN_IDENT;
                    n_run_start = r_pos;
                    n_run_len   = LEN_BITS'(1);
                end else if (is_decimal(c)) begin
                    n_run_kind  = RUN_INT;
                    n_run_start = r_pos;
                    n_run_len   = LEN_BITS'(1);
                end else if (c == CH_EQ) begin
                    n_pend = PEND_EQ;
                end else if (c == CH_BANG) begin
                    n_pend = PEND_BANG;
                end else if (c == CH_COLON) begin
                    n_pend = PEND_COLON;
                end else begin
                    b_on  = 1'b1;
                    b_tok = '{kind: single_kind(c), start: START_BITS'(r_pos),
                              len: LEN_BITS'(1), last: 1'b0};
                end
            end
        end
        a_tok.last = !b_on;
        b_tok.last = 1'b1;
    end

    // pack the tokens of this item into one record
    always_comb begin
        o_rec.cnt  = {1'b0, a_on} + {1'b0, b_on};
        o_rec.tok0 = a_on ? a_tok : b_tok;
        o_rec.tok1 = b_tok;
        o_push     = accept && (a_on || b_on);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_run_kind  <= RUN_NONE;
            r_run_start <= '0;
            r_run_len   <= '0;
            r_pend      <= PEND_NONE;
        end else if (accept) begin
            r_pos       <= n_pos;
            r_run_kind  <= n_run_kind;
            r_run_start <= n_run_start;
            r_run_len   <= n_run_len;
            r_pend      <= n_pend;
        end
    end

endmodule

// ===== src/tks_queue.sv =====
module tks_queue import tks_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_rec   i_rec,
    input  logic   i_pop,
    output t_rec   o_head,
    output t_qstat o_qstat
);

    t_rec                r_mem [QUEUE_DEPTH];
    logic [QIDX_BITS-1:0] r_wr, r_rd;
    logic [QIDX_BITS:0]   r_cnt;
    logic                 do_push, do_pop;

    assign o_qstat.full  = r_cnt == (QIDX_BITS+1)'(QUEUE_DEPTH);
    assign o_qstat.empty = r_cnt == '0;
    assign do_push       = i_push && !o_qstat.full;
    assign do_pop        = i_pop && !o_qstat.empty;
    assign o_head        = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + {{QIDX_BITS{1'b0}}, do_push} - {{QIDX_BITS{1'b0}}, do_pop};
        end
    end

endmodule

// ===== src/tks_back.sv =====
module tks_back import tks_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rec     i_head,
    input  t_qstat   i_qstat,
    output logic     o_pop,
    tks_out_if.source o_out
);

    logic r_valid;
    logic r_have2;
    t_tok r_tok, r_tok2;
    logic load_ok;

    assign load_ok = !r_valid || o_out.ready;
    assign o_pop   = load_ok && !r_have2 && !i_qstat.empty;

    assign o_out.valid     = r_valid;
    assign o_out.kind      = r_tok.kind;
    assign o_out.start_res = r_tok.start;
    assign o_out.length    = r_tok.len;
    assign o_out.last      = r_tok.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_have2 <= 1'b0;
        end else if (load_ok) begin
            if (r_have2) begin
                r_valid <= 1'b1;
                r_have2 <= 1'b0;
            end else if (!i_qstat.empty) begin
                r_valid <= 1'b1;
                r_have2 <= i_head.cnt == 2'd2;
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            if (r_have2) begin
                r_tok <= r_tok2;
            end else if (!i_qstat.empty) begin
                r_tok  <= i_head.tok0;
                r_tok2 <= i_head.tok1;
            end
        end
    end

endmodule

// ===== src/token_scanner_top.sv =====
// token scanner: takes source text one byte per item on i_in (ch, is_end) and
// gives tokens on o_out as kind, start_res (low 16 bits of the byte offset of
// the first character) and length (saturating at 65535). whitespace (space,
// tab, cr, lf) separates tokens and yields nothing; letter/underscore runs are
// identifiers, digit runs are integers, '==', '!=' and ':=' are two-byte
// operators, listed punctuation bytes are single tokens and any other byte is
// illegal. is_end, or a zero byte, flushes any open token, sends eof (length
// 0, start at the current offset) and resets the offset to zero. one input
// item gives zero, one or two tokens, and last marks the final token of each
// item. rate: one byte is accepted every cycle while the queue has room; the
// back end hands out one token per cycle while o_out is ready, so the
// sustained rate is one item per cycle while items average no more than one
// token each, and a four-record queue between the classifying front end and
// the output stage soaks up bursts of two-token items. a token goes through
// the queue write, then the output register, before it shows on o_out. POS_BITS
// sets the width of the internal offset counter, which wraps at its width.
module token_scanner_top import tks_pkg::*; #(
    parameter int POS_BITS = POS_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tks_in_if.sink     i_in,
    tks_out_if.source  o_out
);

    // records travelling from classifier to output stage
    t_rec   push_rec;
    t_rec   head_rec;
    t_qstat qstat;
    logic   push;
    logic   pop;

    // front: classify each byte, track open run and pending operator
    tks_front #(
        .POS_BITS (POS_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_qstat (qstat),
        .o_push  (push),
        .o_rec   (push_rec)
    );

    // short queue so each side can stall on its own
    tks_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (push_rec),
        .i_pop   (pop),
        .o_head  (head_rec),
        .o_qstat (qstat)
    );

    // back: serialise each record into one token per cycle while o_out is ready
    tks_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head_rec),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== src/tks_checker.sv =====
module tks_checker import tks_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic [KIND_BITS-1:0]  i_out_kind,
    input logic [START_BITS-1:0] i_out_start,
    input logic [LEN_BITS-1:0]   i_out_len,
    input logic                  i_out_last
);

    // nothing offered straight after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("token offered after reset");

    // a stalled token holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_kind)
            && $stable(i_out_start) && $stable(i_out_len) && $stable(i_out_last))
        else $error("stalled token changed");

    // eof is empty and always closes its item
    a_eof_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_EOF |-> i_out_len == '0 && i_out_last)
        else $error("malformed eof token");

    // every other token covers at least one byte
    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind != KIND_EOF |-> i_out_len != '0)
        else $error("empty non-eof token");

    // two-byte operators are exactly two bytes long
    a_pair_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_out_kind == KIND_EQ || i_out_kind == KIND_NE
            || i_out_kind == KIND_ALLOCATE) |-> i_out_len == LEN_BITS'(2))
        else $error("two-byte operator with wrong length");

endmodule

bind token_scanner_top tks_checker u_tks_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_kind  (o_out.kind),
    .i_out_start (o_out.start_res),
    .i_out_len   (o_out.length),
    .i_out_last  (o_out.last)
);
